FILE: hw/rtl/frame_bitmap_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Concurrent assertion helpers shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FBA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FBA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg)
`define FBA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Shared types, codes and sizing helpers for the allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int FBA_MAX_FRAMES   = 65536;
    localparam int FBA_FRAME_LIMIT  = 65536;
    localparam int FBA_PADDR_W      = 3;
    localparam int FBA_PDATA_W      = 32;
    localparam int FBA_COUNT_W      = 17;
    localparam int FBA_FRAME_W      = 16;
    localparam logic [FBA_COUNT_W-1:0] FBA_COUNT_RESET = 17'd65536;
    localparam logic FBA_REG_FRAME_COUNT = 1'b0;

    typedef enum logic [1:0] {
        CMD_MAP,
        CMD_ALLOC,
        CMD_UNMAP,
        CMD_FREE
    } fba_cmd_t;

    typedef enum logic [2:0] {
        STAT_DONE,
        STAT_MAPPED,
        STAT_FULL,
        STAT_NOTHING,
        STAT_RANGE
    } fba_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_RD,
        S_FREE_WR,
        S_PUSH
    } fba_state_t;

    typedef struct packed {
        fba_status_t             status;
        logic [FBA_FRAME_W-1:0]  frame_number;
        logic                    update_entry;
        logic                    present_bit;
        logic                    writable_bit;
        logic                    user_bit;
    } fba_result_t;

    function automatic int fba_frame_cap(input int max_frames);
        return (max_frames < FBA_FRAME_LIMIT) ? max_frames : FBA_FRAME_LIMIT;
    endfunction

    function automatic int fba_words(input int max_frames);
        return (fba_frame_cap(max_frames) + 31) >> 5;
    endfunction

    function automatic int fba_addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

FILE: hw/rtl/fba_zero_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator zero finder
// Locates the lowest clear bit of one 32-bit bitmap word.
// ----------------------------------------------------------------------------
module fba_zero_find (
    input  logic [31:0] word_in,
    output logic        found,
    output logic [4:0]  bit_index
);

    always_comb begin
        bit_index = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (!word_in[i]) begin
                bit_index = 5'(i);
            end
        end
    end

    assign found = ~&word_in;

endmodule

FILE: hw/rtl/fba_bitmap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator bitmap memory
// Single-port word memory holding the used/free bits, registered read.
// ----------------------------------------------------------------------------
module fba_bitmap_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic          wr_en,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/fba_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator register port
// APB-style access to the frame count register.
// ----------------------------------------------------------------------------
module fba_apb_regs
    import fba_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [FBA_PADDR_W-1:0] paddr,
    input  logic [FBA_PDATA_W-1:0] pwdata,
    output logic [FBA_PDATA_W-1:0] prdata,
    output logic                   pready,
    output logic [FBA_COUNT_W-1:0] frame_count
);

    logic [FBA_COUNT_W-1:0] frame_count_reg;
    logic                   sel_count;

    assign pready    = 1'b1;
    assign sel_count = (paddr[FBA_PADDR_W-1] == FBA_REG_FRAME_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= FBA_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && sel_count) begin
            frame_count_reg <= pwdata[FBA_COUNT_W-1:0];
        end
    end

    assign prdata      = sel_count ? FBA_PDATA_W'(frame_count_reg) : '0;
    assign frame_count = frame_count_reg;

endmodule

FILE: hw/rtl/fba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator sequencer
// Steps through the bitmap one word at a time and builds each result word.
// ----------------------------------------------------------------------------
module fba_ctrl
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = FBA_MAX_FRAMES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [FBA_COUNT_W-1:0]       frame_count,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [FBA_FRAME_W-1:0]       s_current_frame,
    input  logic                         s_is_kernel,
    input  logic                         s_is_writable,
    input  logic [FBA_FRAME_W-1:0]       s_free_number,
    output logic                         m_valid,
    input  logic                         m_ready,
    output fba_result_t                  m_result,
    output logic                         ram_rd_en,
    output logic                         ram_wr_en,
    output logic [fba_addr_bits(fba_words(MAX_FRAMES))-1:0] ram_addr,
    output logic [31:0]                  ram_wdata,
    input  logic [31:0]                  ram_rdata
);

    localparam int DEPTH = fba_words(MAX_FRAMES);
    localparam int AW    = fba_addr_bits(DEPTH);
    localparam int CAP   = fba_frame_cap(MAX_FRAMES);

    fba_state_t             state_reg, state_next;
    fba_cmd_t               cmd_reg, cmd_next;
    logic [FBA_FRAME_W-1:0] cur_reg, cur_next;
    logic [FBA_FRAME_W-1:0] target_reg, target_next;
    logic                   kern_reg, kern_next;
    logic                   wr_reg, wr_next;
    logic [AW:0]            ptr_reg, ptr_next;
    logic [AW:0]            fill_reg, fill_next;
    fba_result_t            res_reg, res_next;
    fba_result_t            out_reg, out_next;
    logic                   m_valid_reg, m_valid_next;

    logic [FBA_COUNT_W-1:0] lim;
    logic [FBA_COUNT_W:0]   lim_round;
    logic [AW:0]            words;
    logic [AW-1:0]          tgt_word;
    logic [31:0]            tgt_mask;
    logic                   tgt_in_range;
    logic                   tgt_written;
    logic                   is_release;
    logic [31:0]            scan_word;
    logic                   zf_found;
    logic [4:0]             zf_bit;
    logic [FBA_COUNT_W-1:0] scan_idx;
    logic                   scan_ok;
    logic                   out_free;

    assign lim = (frame_count > FBA_COUNT_W'(CAP)) ? FBA_COUNT_W'(CAP) : frame_count;
    assign lim_round = {1'b0, lim} + (FBA_COUNT_W + 1)'(31);
    assign words = lim_round[AW+5:5];

    assign tgt_word     = target_reg[AW+4:5];
    assign tgt_mask     = 32'd1 << target_reg[4:0];
    assign tgt_in_range = ({1'b0, target_reg} < lim);
    assign tgt_written  = ({1'b0, tgt_word} < fill_reg);
    assign is_release   = (cmd_reg == CMD_UNMAP) || (cmd_reg == CMD_FREE);

    assign scan_word = (ptr_reg < fill_reg) ? ram_rdata : '0;
    assign scan_idx  = FBA_COUNT_W'({ptr_reg[AW-1:0], zf_bit});
    assign scan_ok   = zf_found && (scan_idx < lim);
    assign out_free  = !m_valid_reg || m_ready;

    fba_zero_find u_zero_find (
        .word_in   (scan_word),
        .found     (zf_found),
        .bit_index (zf_bit)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (cmd_reg == CMD_MAP && cur_reg != '0) begin
                    state_next = S_PUSH;
                end else if (!is_release) begin
                    state_next = S_SCAN_RD;
                end else if (cmd_reg == CMD_UNMAP && cur_reg == '0) begin
                    state_next = S_PUSH;
                end else if (!tgt_in_range || !tgt_written) begin
                    state_next = S_PUSH;
                end else begin
                    state_next = S_FREE_RD;
                end
            end
            S_SCAN_RD: begin
                state_next = (ptr_reg == words) ? S_PUSH : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                state_next = zf_found ? S_PUSH : S_SCAN_RD;
            end
            S_FREE_RD: begin
                state_next = S_FREE_WR;
            end
            S_FREE_WR: begin
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_next     = cmd_reg;
        cur_next     = cur_reg;
        target_next  = target_reg;
        kern_next    = kern_reg;
        wr_next      = wr_reg;
        ptr_next     = ptr_reg;
        fill_next    = fill_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_rd_en    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_addr     = ptr_reg[AW-1:0];
        ram_wdata    = scan_word | (32'd1 << zf_bit);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next    = fba_cmd_t'(s_cmd);
                    cur_next    = s_current_frame;
                    kern_next   = s_is_kernel;
                    wr_next     = s_is_writable;
                    target_next = (fba_cmd_t'(s_cmd) == CMD_UNMAP) ? s_current_frame
                                                                  : s_free_number;
                    ptr_next    = '0;
                end
            end
            S_DECODE: begin
                res_next = '0;
                if (cmd_reg == CMD_MAP && cur_reg != '0) begin
                    res_next.status = STAT_MAPPED;
                end else if (is_release) begin
                    if (cmd_reg == CMD_UNMAP && cur_reg == '0) begin
                        res_next.status = STAT_NOTHING;
                    end else if (!tgt_in_range) begin
                        res_next.status = STAT_RANGE;
                    end else begin
                        res_next.update_entry = (cmd_reg == CMD_UNMAP);
                    end
                end
            end
            S_SCAN_RD: begin
                if (ptr_reg == words) begin
                    res_next.status = STAT_FULL;
                end else begin
                    ram_rd_en = 1'b1;
                end
            end
            S_SCAN_CHK: begin
                if (zf_found) begin
                    if (scan_ok) begin
                        ram_wr_en = 1'b1;
                        if (ptr_reg == fill_reg) begin
                            fill_next = fill_reg + 1'b1;
                        end
                        res_next.frame_number = scan_idx[FBA_FRAME_W-1:0];
                        if (cmd_reg == CMD_MAP) begin
                            res_next.update_entry = 1'b1;
                            res_next.present_bit  = 1'b1;
                            res_next.writable_bit = wr_reg;
                            res_next.user_bit     = !kern_reg;
                        end
                    end else begin
                        res_next.status = STAT_FULL;
                    end
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_FREE_RD: begin
                ram_rd_en = 1'b1;
                ram_addr  = tgt_word;
            end
            S_FREE_WR: begin
                ram_wr_en = 1'b1;
                ram_addr  = tgt_word;
                ram_wdata = ram_rdata & ~tgt_mask;
            end
            S_PUSH: begin
                if (out_free) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        target_reg <= target_next;
        kern_reg   <= kern_next;
        wr_reg     <= wr_next;
        ptr_reg    <= ptr_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

endmodule

FILE: hw/rtl/frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator core
// First-fit physical frame allocator over a used/free bitmap.
// ----------------------------------------------------------------------------
// Usage: a command word enters on the s_ channel (valid/ready) and exactly
// one result word leaves on the m_ channel for each command. The user must
// write the frame count register through the APB-style port only while the
// block is idle; the block itself does not enforce this. Map with a zero
// current frame and allocate scan the bitmap from word 0, one 32-frame word
// at a time. Unmap and free clear one bit by a read-modify-write of one
// bitmap word, unless the command fails or that word was never written.
// The block works on one command at a time; s_ready rises again once the
// result is in the output register, so the next command can be taken while
// that result still waits for m_ready. A stalled receiver holds the result
// and, after one more command, holds the block before it enters the idle
// state.
// Reset clears the control state and a fill count of written bitmap words;
// words from that count on read as free, so no clearing pass is needed and
// the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "frame_bitmap_allocator_core_defines.svh"

module frame_bitmap_allocator_core
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = FBA_MAX_FRAMES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [FBA_PADDR_W-1:0] paddr,
    input  logic [FBA_PDATA_W-1:0] pwdata,
    output logic [FBA_PDATA_W-1:0] prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_cmd,
    input  logic [FBA_FRAME_W-1:0] s_current_frame,
    input  logic                   s_is_kernel,
    input  logic                   s_is_writable,
    input  logic [FBA_FRAME_W-1:0] s_free_number,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [FBA_FRAME_W-1:0] m_frame_number,
    output logic                   m_update_entry,
    output logic                   m_present_bit,
    output logic                   m_writable_bit,
    output logic                   m_user_bit
);

    localparam int DEPTH = fba_words(MAX_FRAMES);
    localparam int AW    = fba_addr_bits(DEPTH);

    logic [FBA_COUNT_W-1:0] frame_count;
    fba_result_t            result;
    logic                   ram_rd_en;
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_addr;
    logic [31:0]            ram_wdata;
    logic [31:0]            ram_rdata;

    fba_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frame_count (frame_count)
    );

    fba_bitmap_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .aclk  (aclk),
        .rd_en (ram_rd_en),
        .wr_en (ram_wr_en),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    fba_ctrl #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .frame_count     (frame_count),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_current_frame (s_current_frame),
        .s_is_kernel     (s_is_kernel),
        .s_is_writable   (s_is_writable),
        .s_free_number   (s_free_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result        (result),
        .ram_rd_en       (ram_rd_en),
        .ram_wr_en       (ram_wr_en),
        .ram_addr        (ram_addr),
        .ram_wdata       (ram_wdata),
        .ram_rdata       (ram_rdata)
    );

    assign m_status       = result.status;
    assign m_frame_number = result.frame_number;
    assign m_update_entry = result.update_entry;
    assign m_present_bit  = result.present_bit;
    assign m_writable_bit = result.writable_bit;
    assign m_user_bit     = result.user_bit;

    `FBA_ASSERT_NEXT(a_one_word_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready,
        "command taken while busy")
    `FBA_ASSERT_NOW(a_update_needs_done, aclk, aresetn, m_valid && m_update_entry,
        m_status == STAT_DONE, "entry update on failed command")
    `FBA_ASSERT_NOW(a_entry_bits_need_update, aclk, aresetn,
        m_valid && (m_present_bit || m_writable_bit || m_user_bit), m_update_entry,
        "entry bits without update")
    `FBA_ASSERT_NOW(a_failure_has_no_frame, aclk, aresetn, m_valid && m_status != STAT_DONE,
        m_frame_number == '0, "frame number on failed command")

endmodule

FILE: tb/sv/frame_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator core testbench
// Sends map, allocate, unmap and free command words to the allocator and
// checks each result word against a bitmap predictor kept in the bench.
// The frame count register is set through the APB port between phases,
// including zero, one, word boundaries and values above the frame space.
// Both handshake sides idle at random, except in one phase where neither does.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core_tb;
    import fba_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAP_WORDS = FBA_MAX_FRAMES / 32;
    localparam int FRAME_SPACE = 1 << FBA_FRAME_W;
    localparam logic [FBA_PADDR_W-1:0] FRAME_COUNT_ADDR = FBA_PADDR_W'(4 * FBA_REG_FRAME_COUNT);

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [FBA_PADDR_W-1:0] paddr = '0;
    logic [FBA_PDATA_W-1:0] pwdata = '0;
    logic [FBA_PDATA_W-1:0] prdata;
    logic                   pready;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_cmd = '0;
    logic [FBA_FRAME_W-1:0] s_current_frame = '0;
    logic                   s_is_kernel = 1'b0;
    logic                   s_is_writable = 1'b0;
    logic [FBA_FRAME_W-1:0] s_free_number = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [2:0]             m_status;
    logic [FBA_FRAME_W-1:0] m_frame_number;
    logic                   m_update_entry;
    logic                   m_present_bit;
    logic                   m_writable_bit;
    logic                   m_user_bit;

    bit [31:0]              frame_map [MAP_WORDS];
    logic [FBA_COUNT_W-1:0] frame_count_shadow = FBA_COUNT_RESET;
    fba_result_t            pending_results [$];
    logic [FBA_FRAME_W-1:0] held_frames [$];
    int                     tx_idle_pct = 15;
    int                     rx_idle_pct = 15;
    int                     fail_count = 0;
    int unsigned            cycle_count = 0;

    frame_bitmap_allocator_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_current_frame (s_current_frame),
        .s_is_kernel     (s_is_kernel),
        .s_is_writable   (s_is_writable),
        .s_free_number   (s_free_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_frame_number  (m_frame_number),
        .m_update_entry  (m_update_entry),
        .m_present_bit   (m_present_bit),
        .m_writable_bit  (m_writable_bit),
        .m_user_bit      (m_user_bit)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic void note_failure(string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endfunction

    function automatic int usable_frames();
        int lim;
        lim = int'(frame_count_shadow);
        if (lim > FBA_MAX_FRAMES) begin
            lim = FBA_MAX_FRAMES;
        end
        if (lim > FRAME_SPACE) begin
            lim = FRAME_SPACE;
        end
        return lim;
    endfunction

    function automatic bit lowest_free(output int idx);
        int lim;
        int words;
        lim = usable_frames();
        words = (lim + 31) / 32;
        idx = 0;
        for (int w = 0; w < words; w++) begin
            if (frame_map[w] != 32'hFFFF_FFFF) begin
                for (int b = 0; b < 32; b++) begin
                    if (!frame_map[w][b]) begin
                        idx = w * 32 + b;
                        return idx < lim;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic bit release_frame(int idx);
        if (idx >= usable_frames()) begin
            return 1'b0;
        end
        frame_map[idx >> 5][idx & 31] = 1'b0;
        return 1'b1;
    endfunction

    function automatic fba_result_t apply_command(fba_cmd_t cmd, logic [15:0] cur, logic kern,
                                                  logic wr, logic [15:0] fnum);
        fba_result_t res;
        int idx;
        res = '0;
        res.status = STAT_DONE;
        case (cmd)
            CMD_MAP, CMD_ALLOC: begin
                if (cmd == CMD_MAP && cur != '0) begin
                    res.status = STAT_MAPPED;
                end else if (!lowest_free(idx)) begin
                    res.status = STAT_FULL;
                end else begin
                    frame_map[idx >> 5][idx & 31] = 1'b1;
                    res.frame_number = FBA_FRAME_W'(idx);
                    if (cmd == CMD_MAP) begin
                        res.update_entry = 1'b1;
                        res.present_bit = 1'b1;
                        res.writable_bit = wr;
                        res.user_bit = ~kern;
                    end
                end
            end
            CMD_UNMAP: begin
                if (cur == '0) begin
                    res.status = STAT_NOTHING;
                end else if (!release_frame(int'(cur))) begin
                    res.status = STAT_RANGE;
                end else begin
                    res.update_entry = 1'b1;
                end
            end
            default: begin
                if (!release_frame(int'(fnum))) begin
                    res.status = STAT_RANGE;
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        fba_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result word with none expected: status=%0d frame=%0d",
                                       m_status, m_frame_number));
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_frame_number !== want.frame_number ||
                    m_update_entry !== want.update_entry ||
                    m_present_bit !== want.present_bit ||
                    m_writable_bit !== want.writable_bit || m_user_bit !== want.user_bit) begin
                    note_failure($sformatf(
                        "mismatch: exp st=%0d fr=%0d upd=%0b p=%0b w=%0b u=%0b, got st=%0d fr=%0d upd=%0b p=%0b w=%0b u=%0b",
                        want.status, want.frame_number, want.update_entry, want.present_bit,
                        want.writable_bit, want.user_bit, m_status, m_frame_number,
                        m_update_entry, m_present_bit, m_writable_bit, m_user_bit));
                end
            end
        end
    end

    task automatic send_word(input fba_cmd_t cmd, input logic [15:0] cur, input logic kern,
                             input logic wr, input logic [15:0] fnum);
        fba_result_t res;
        logic [15:0] gone;
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_current_frame <= cur;
        s_is_kernel <= kern;
        s_is_writable <= wr;
        s_free_number <= fnum;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        res = apply_command(cmd, cur, kern, wr, fnum);
        pending_results.push_back(res);
        if (res.status == STAT_DONE) begin
            if (cmd == CMD_MAP || cmd == CMD_ALLOC) begin
                held_frames.push_back(res.frame_number);
            end else begin
                gone = (cmd == CMD_UNMAP) ? cur : fnum;
                for (int i = held_frames.size() - 1; i >= 0; i--) begin
                    if (held_frames[i] == gone) begin
                        held_frames.delete(i);
                    end
                end
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_frame_count(input logic [FBA_COUNT_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= FRAME_COUNT_ADDR;
        pwdata <= FBA_PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        frame_count_shadow = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (prdata !== FBA_PDATA_W'(value)) begin
            note_failure($sformatf("frame count read back %0d, wrote %0d", prdata, value));
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] pick_frame();
        int r;
        int lim;
        r = $urandom_range(0, 9);
        lim = usable_frames();
        if (r < 6 && held_frames.size() != 0) begin
            return held_frames[$urandom_range(0, held_frames.size() - 1)];
        end
        if (r < 8) begin
            return 16'($urandom_range(0, lim + 3));
        end
        return 16'($urandom);
    endfunction

    task automatic send_random_word();
        fba_cmd_t cmd;
        logic [15:0] cur;
        logic [15:0] fnum;
        int r;
        r = $urandom_range(0, 99);
        cur = 16'($urandom);
        fnum = 16'($urandom);
        if (r < 30) begin
            cmd = CMD_MAP;
            if ($urandom_range(0, 3) != 0) begin
                cur = '0;
            end
        end else if (r < 50) begin
            cmd = CMD_ALLOC;
        end else if (r < 75) begin
            cmd = CMD_UNMAP;
            if ($urandom_range(0, 9) != 0) begin
                cur = pick_frame();
            end
        end else begin
            cmd = CMD_FREE;
            fnum = pick_frame();
        end
        send_word(cmd, cur, 1'($urandom), 1'($urandom), fnum);
    endtask

    task automatic test_directed_cases();
        send_word(CMD_MAP, 16'h0000, 1'b0, 1'b1, 16'hFFFF);
        send_word(CMD_MAP, 16'h0000, 1'b1, 1'b0, 16'h0000);
        send_word(CMD_MAP, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_word(CMD_ALLOC, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
        send_word(CMD_UNMAP, 16'h0000, 1'b0, 1'b0, 16'hFFFF);
        send_word(CMD_UNMAP, 16'h0001, 1'b1, 1'b1, 16'h0000);
        send_word(CMD_FREE, 16'hFFFF, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_FREE, 16'h0000, 1'b1, 1'b1, 16'h0000);
        send_word(CMD_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_MAP, 16'h0000, 1'b1, 1'b1, 16'hFFFF);
        send_word(CMD_UNMAP, 16'hFFFF, 1'b0, 1'b1, 16'h0000);
        send_word(CMD_FREE, 16'h0000, 1'b0, 1'b0, 16'hFFFF);
        write_frame_count('0);
        send_word(CMD_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_MAP, 16'h0000, 1'b0, 1'b1, 16'h0000);
        send_word(CMD_FREE, 16'hFFFF, 1'b1, 1'b0, 16'h0000);
        send_word(CMD_UNMAP, 16'h0005, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_MAP, 16'hFFFF, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_UNMAP, 16'h0000, 1'b1, 1'b1, 16'h0000);
        write_frame_count(17'd1);
        send_word(CMD_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_FREE, 16'h0000, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_FREE, 16'h0000, 1'b0, 1'b0, 16'h0001);
        write_frame_count(17'h1FFFF);
        send_word(CMD_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0000);
    endtask

    task automatic test_bitmap_full();
        write_frame_count(17'd33);
        for (int i = 0; i < 36; i++) begin
            send_word(i[0] ? CMD_MAP : CMD_ALLOC, 16'h0000, 1'($urandom), 1'($urandom),
                      16'($urandom));
        end
        send_word(CMD_FREE, 16'($urandom), 1'b0, 1'b0, 16'd32);
        send_word(CMD_MAP, 16'h0000, 1'b0, 1'b1, 16'($urandom));
        send_word(CMD_UNMAP, 16'd7, 1'b0, 1'b0, 16'($urandom));
        send_word(CMD_ALLOC, 16'($urandom), 1'b0, 1'b0, 16'($urandom));
        send_word(CMD_FREE, 16'($urandom), 1'b0, 1'b0, 16'd33);
        send_word(CMD_UNMAP, 16'd33, 1'b0, 1'b0, 16'($urandom));
    endtask

    task automatic test_limit_shrink();
        write_frame_count(17'd20);
        send_word(CMD_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_FREE, 16'h0000, 1'b0, 1'b0, 16'd25);
        send_word(CMD_UNMAP, 16'd30, 1'b0, 1'b0, 16'h0000);
        send_word(CMD_FREE, 16'h0000, 1'b0, 1'b0, 16'd19);
        send_word(CMD_MAP, 16'h0000, 1'b1, 1'b0, 16'h0000);
        write_frame_count(17'd33);
        send_word(CMD_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0000);
        write_frame_count(17'd32);
        send_word(CMD_FREE, 16'h0000, 1'b0, 1'b0, 16'd31);
        send_word(CMD_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0000);
    endtask

    task automatic test_random_phases();
        logic [FBA_COUNT_W-1:0] limits [8];
        limits = '{17'd65536, 17'd48, 17'h1FFFF, 17'd1, 17'd100, 17'd0, 17'd33, 17'd65536};
        for (int p = 0; p < 8; p++) begin
            write_frame_count(limits[p]);
            tx_idle_pct = (p == 2) ? 0 : 15;
            rx_idle_pct = (p == 2) ? 0 : 15;
            for (int i = 0; i < 130; i++) begin
                if (p == 4 && i == 60) begin
                    wait_drained();
                end
                send_random_word();
            end
        end
        tx_idle_pct = 15;
        rx_idle_pct = 15;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_bitmap_full();
        test_limit_shrink();
        test_random_phases();
        wait_drained();
        repeat (12) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
